/* rtl/core/mac_pkg.sv */
// ----------------------------------------------------------------------------
// mac_pkg
// Types and constants shared by the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mac_pkg;

	typedef enum logic [4:0] {
		OP_MUL_S = 5'd0, OP_MUL_U = 5'd1, OP_MUL_F = 5'd2, OP_PSHL = 5'd3,
		OP_PSHR = 5'd4, OP_ACC_ADD = 5'd5, OP_ACC_SUB = 5'd6, OP_SAT_S = 5'd7,
		OP_SAT_U = 5'd8, OP_SAT_F = 5'd9, OP_CLR_FLAGS = 5'd10,
		OP_SET_FLAGS = 5'd11, OP_RD_F = 5'd12, OP_RD_I = 5'd13,
		OP_RD_SS = 5'd14, OP_RD_US = 5'd15, OP_CLR_ACC = 5'd16,
		OP_MOVE = 5'd17, OP_RD_EXT_F = 5'd18, OP_RD_EXT_I = 5'd19,
		OP_WR_F = 5'd20, OP_WR_S = 5'd21, OP_WR_U = 5'd22,
		OP_WR_EXT_F = 5'd23, OP_WR_EXT_S = 5'd24, OP_WR_EXT_U = 5'd25
	} opcode_t;

	localparam logic [1:0] CFG_SATURATE = 2'd0;
	localparam logic [1:0] CFG_SHORT    = 2'd1;
	localparam logic [1:0] CFG_FRACTION = 2'd2;
	localparam logic [1:0] CFG_ROUND    = 2'd3;

	localparam logic [63:0] BIT50   = 64'd1 << 50;
	localparam logic [63:0] MASK48  = (64'd1 << 48) - 64'd1;
	localparam logic [63:0] BIT53   = 64'd1 << 53;
	localparam logic [63:0] CLAMP_S = 64'h7fff_ffff;
	localparam logic [63:0] CLAMP_F = 64'h7fff_ffff_ffff;
	localparam logic [63:0] EXT_MID = 64'hff_ffff_ff00;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [1:0]  acc_index;
		logic [1:0]  src_index;
	} mac_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        overflow;
		logic        zero_flag;
		logic        negative_flag;
		logic        ext_overflow;
		logic [3:0]  pav_flags;
	} mac_out_t;

	typedef struct packed {
		logic saturate;
		logic short_m;
		logic fraction;
		logic rnd;
	} mac_cfg_t;

	// request after classification, with the raw product already formed
	typedef struct packed {
		mac_in_t     req;
		logic        valid_acc;
		logic        pair_ok;
		logic [63:0] prod;
	} mac_cmd_t;

	function automatic logic [63:0] round_even(input logic [63:0] v,
		input logic [63:0] rem, input logic [63:0] half);
		if (rem > half) return v + 64'd1;
		if (rem == half) return v + {63'd0, v[0]};
		return v;
	endfunction

endpackage

/* rtl/core/multiply_accumulate_unit.sv */
// Pipeline: a request passes the product register, the queue and the execute stage.
// Throughput: one request per cycle while the output is not stalled; the 32x32
// multiply is done in the front stage and the 64-bit accumulate in the back stage.
// Reset: arst_n clears accumulators, product register, flags, mode bits and
// all valid state at once.
// ----------------------------------------------------------------------------
// multiply_accumulate_unit
// Four-accumulator MAC with product register and sticky status flags.
// ----------------------------------------------------------------------------
module multiply_accumulate_unit #(
	parameter int NUM_ACCS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mac_pkg::mac_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mac_pkg::mac_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data
);
	import mac_pkg::*;

	mac_cfg_t cfg_q;
	logic     f_valid, f_ready, b_valid, b_ready;
	mac_cmd_t f_cmd, b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SATURATE: cfg_q.saturate <= cfg_data;
				CFG_SHORT:    cfg_q.short_m <= cfg_data;
				CFG_FRACTION: cfg_q.fraction <= cfg_data;
				CFG_ROUND:    cfg_q.rnd <= cfg_data;
				default: ;
			endcase
		end
	end

	mac_front #(.NUM_ACCS(NUM_ACCS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_req(in_data),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	mac_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	mac_back #(.NUM_ACCS(NUM_ACCS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(b_cmd), .out_valid, .out_ready, .out_data
	);
endmodule

/* rtl/core/mac_front.sv */
// ----------------------------------------------------------------------------
// mac_front
// Accepts requests, checks indices, forms the 32x32 product into a register.
// ----------------------------------------------------------------------------
module mac_front #(
	parameter int NUM_ACCS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mac_pkg::mac_in_t in_req,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output mac_pkg::mac_cmd_t cmd
);
	import mac_pkg::*;

	logic               valid_s1;
	mac_cmd_t           cmd_s1;
	logic signed [32:0] sa, sb;
	logic signed [65:0] prod_w;
	logic               signed_mul;
	logic [2:0]         bi;

	assign in_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;
	assign bi = {1'b0, in_req.acc_index} + 3'd1;

	// one extra bit carries the sign, so signed and unsigned share the multiplier
	always_comb begin
		signed_mul = (in_req.opcode != OP_MUL_U);
		sa = {in_req.operand_a[31] & signed_mul, in_req.operand_a};
		sb = {in_req.operand_b[31] & signed_mul, in_req.operand_b};
		prod_w = sa * sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.req <= in_req;
			cmd_s1.valid_acc <= (32'(in_req.acc_index) < NUM_ACCS) &&
				!(in_req.opcode == OP_MOVE && 32'(in_req.src_index) >= NUM_ACCS);
			cmd_s1.pair_ok <= 32'(bi) < NUM_ACCS;
			cmd_s1.prod <= prod_w[63:0];
		end
	end
endmodule

/* rtl/core/mac_queue.sv */
// ----------------------------------------------------------------------------
// mac_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module mac_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  mac_pkg::mac_cmd_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output mac_pkg::mac_cmd_t rd_data
);
	import mac_pkg::*;

	mac_cmd_t mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

/* rtl/core/mac_back.sv */
// ----------------------------------------------------------------------------
// mac_back
// Executes requests on the accumulators, product register and flags.
// ----------------------------------------------------------------------------
module mac_back #(
	parameter int NUM_ACCS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_pkg::mac_cfg_t cfg,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  mac_pkg::mac_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output mac_pkg::mac_out_t out_data
);
	import mac_pkg::*;

	logic [63:0] acc_q [NUM_ACCS];
	logic [63:0] prod_q;
	logic [3:0]  flags_q;
	logic [NUM_ACCS-1:0] pav_q;
	logic        valid_q;
	mac_out_t    out_q;

	logic [63:0] acc_n [NUM_ACCS];
	logic [63:0] prod_n;
	logic [3:0]  flags_n;
	logic [NUM_ACCS-1:0] pav_n;
	logic [31:0] rd;
	logic [63:0] v, hi, p, t, lo, nh, sv;
	logic [1:0]  x, bx;
	logic        fire;

	assign cmd_ready = !valid_q || out_ready;
	assign fire = cmd_valid && cmd_ready;
	assign out_valid = valid_q;
	assign out_data = out_q;

	always_comb begin
		x = cmd.req.acc_index;
		bx = x + 2'd1;
		for (int i = 0; i < NUM_ACCS; i++) acc_n[i] = acc_q[i];
		prod_n = prod_q;
		flags_n = flags_q;
		pav_n = pav_q;
		rd = 32'd0;
		p = cmd.prod;
		t = 64'd0;
		lo = 64'd0;
		nh = 64'd0;
		sv = 64'd0;
		v = 64'd0;
		hi = 64'd0;
		if (cmd.valid_acc) v = acc_q[x[$clog2(NUM_ACCS)-1:0]];
		if (cmd.pair_ok) hi = acc_q[bx[$clog2(NUM_ACCS)-1:0]];
		case (cmd.req.opcode)
			OP_MUL_S: begin
				t = {{24{p[39]}}, p[39:0]};
				if (t != p) begin
					flags_n[0] = 1'b1;
					if (cfg.saturate) t = p[63] ? ~BIT50 : BIT50;
				end
				prod_n = t;
			end
			OP_MUL_U: begin
				t = p;
				if (p[63:40] != 24'd0) begin
					flags_n[0] = 1'b1;
					t = cfg.saturate ? BIT50 : {24'd0, p[39:0]};
				end
				prod_n = t;
			end
			OP_MUL_F: begin
				t = {{24{p[63]}}, p[63:24]};
				prod_n = cfg.rnd ? round_even(t, {40'd0, p[23:0]}, 64'h80_0000) : t;
			end
			OP_PSHL: prod_n = {prod_q[62:0], 1'b0};
			OP_PSHR: prod_n = {1'b0, prod_q[63:1]};
			OP_CLR_FLAGS: flags_n = 4'd0;
			default: begin
				if (cmd.valid_acc) begin
					case (cmd.req.opcode)
						OP_ACC_ADD: acc_n[x] = v + prod_q;
						OP_ACC_SUB: acc_n[x] = v - prod_q;
						OP_SAT_S, OP_SAT_F: begin
							sv = {{16{v[47]}}, v[47:0]};
							if (sv != v) flags_n[0] = 1'b1;
							if (flags_n[0]) begin
								pav_n[x] = 1'b1;
								if (cfg.saturate) begin
									t = (cmd.req.opcode == OP_SAT_S) ? CLAMP_S : CLAMP_F;
									sv = sv[63] ? ~t : t;
								end
							end
							acc_n[x] = sv;
						end
						OP_SAT_U: begin
							sv = v;
							if (v[63:48] != 16'd0) flags_n[0] = 1'b1;
							if (flags_n[0]) begin
								pav_n[x] = 1'b1;
								if (cfg.saturate) sv = (v > BIT53) ? 64'd0 : MASK48;
								else sv = v & MASK48;
							end
							acc_n[x] = sv;
						end
						OP_SET_FLAGS: begin
							if (v == 64'd0) flags_n[1] = 1'b1;
							else if (v[47]) flags_n[2] = 1'b1;
							if (pav_q[x]) flags_n[0] = 1'b1;
							if (cfg.fraction) begin
								if (v[63:40] != 24'd0 && v[63:40] != '1) flags_n[3] = 1'b1;
							end else if (cfg.short_m) begin
								if (v[63:32] != 32'd0 && v[63:32] != '1) flags_n[3] = 1'b1;
							end else if (v[63:32] != 32'd0) flags_n[3] = 1'b1;
						end
						OP_RD_F: begin
							if (cfg.short_m) begin
								t = round_even({48'd0, v[39:24]}, {40'd0, v[23:0]}, 64'h80_0000);
								if (cfg.saturate && t > 64'hffff) rd = 32'h7fff;
								else rd = {16'd0, t[15:0]};
							end else begin
								t = {{8{v[63]}}, v[63:8]};
								if (cfg.rnd) t = round_even(t, {56'd0, v[7:0]}, 64'h80);
								if (cfg.saturate && t[63:31] != 33'd0 && t[63:31] != '1)
									rd = t[63] ? 32'h8000_0000 : 32'h7fff_ffff;
								else rd = t[31:0];
							end
						end
						OP_RD_I: rd = v[31:0];
						OP_RD_SS: begin
							if (v[63:31] == 33'd0 || v[63:31] == '1) rd = v[31:0];
							else rd = v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
						end
						OP_RD_US: rd = (v[63:32] != 32'd0) ? 32'hffff_ffff : v[31:0];
						OP_CLR_ACC: begin
							acc_n[x] = 64'd0;
							pav_n[x] = 1'b0;
						end
						OP_MOVE: begin
							acc_n[x] = acc_q[cmd.req.src_index[$clog2(NUM_ACCS)-1:0]];
							pav_n[x] = pav_q[cmd.req.src_index[$clog2(NUM_ACCS)-1:0]];
						end
						OP_RD_EXT_F: rd = {hi[47:40], hi[7:0], v[47:40], v[7:0]};
						OP_RD_EXT_I: rd = {hi[47:32], v[47:32]};
						OP_WR_F, OP_WR_S, OP_WR_U: begin
							t = {{32{cmd.req.operand_a[31]}}, cmd.req.operand_a};
							if (cmd.req.opcode == OP_WR_F) acc_n[x] = {t[55:0], 8'd0};
							else if (cmd.req.opcode == OP_WR_S) acc_n[x] = t;
							else acc_n[x] = {32'd0, cmd.req.operand_a};
							pav_n[x] = 1'b0;
						end
						OP_WR_EXT_F, OP_WR_EXT_S, OP_WR_EXT_U: begin
							if (cmd.req.opcode == OP_WR_EXT_F) begin
								lo = (v & EXT_MID) | {{16{cmd.req.operand_a[15]}},
									cmd.req.operand_a[15:8], 32'd0, cmd.req.operand_a[7:0]};
								nh = (hi & EXT_MID) | {{16{cmd.req.operand_a[31]}},
									cmd.req.operand_a[31:24], 32'd0, cmd.req.operand_a[23:16]};
							end else if (cmd.req.opcode == OP_WR_EXT_S) begin
								lo = {{16{cmd.req.operand_a[15]}}, cmd.req.operand_a[15:0], v[31:0]};
								nh = {{16{cmd.req.operand_a[31]}}, cmd.req.operand_a[31:16],
									hi[31:0]};
							end else begin
								lo = {16'd0, cmd.req.operand_a[15:0], v[31:0]};
								nh = {16'd0, cmd.req.operand_a[31:16], hi[31:0]};
							end
							acc_n[x] = lo;
							if (cmd.pair_ok) acc_n[bx] = nh;
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACCS; i++) acc_q[i] <= 64'd0;
			prod_q <= 64'd0;
			flags_q <= 4'd0;
			pav_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd_ready) valid_q <= cmd_valid;
			if (fire) begin
				for (int i = 0; i < NUM_ACCS; i++) acc_q[i] <= acc_n[i];
				prod_q <= prod_n;
				flags_q <= flags_n;
				pav_q <= pav_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.read_data <= rd;
			out_q.overflow <= flags_n[0];
			out_q.zero_flag <= flags_n[1];
			out_q.negative_flag <= flags_n[2];
			out_q.ext_overflow <= flags_n[3];
			out_q.pav_flags <= 4'(pav_n);
		end
	end
endmodule

/* rtl/core/mac_checker.sv */
// ----------------------------------------------------------------------------
// mac_checker
// Port-level checks on the multiply-accumulate unit.
// ----------------------------------------------------------------------------
module mac_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input mac_pkg::mac_out_t out_data
);
	import mac_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_valid && in_ready) && !$past(out_valid) && !$past(in_valid, 2)
		&& !$past(out_valid, 2) && !$past(in_valid, 3) |-> !out_valid)
		else $error("result without request");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result during reset");
endmodule

bind multiply_accumulate_unit mac_checker u_mac_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

/* tb/tb_multiply_accumulate_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiply_accumulate_unit
// Self-checking bench for the MAC unit: a predictor tracks accumulators,
// product register and flags, and every response is checked against it.
// ----------------------------------------------------------------------------
module tb_multiply_accumulate_unit;
	import mac_pkg::*;

	localparam int N_ACC = 4;
	localparam logic [63:0] MSK40 = (64'd1 << 40) - 64'd1;

	class mac_scoreboard;
		logic [63:0] acc [4];
		logic [63:0] prod;
		logic        fv, fz, fn, fev;
		logic [3:0]  pav;
		mac_cfg_t    mode;
		mac_out_t    pending [$];
		int          errors;

		function void clear();
			foreach (acc[i]) acc[i] = '0;
			prod = '0; fv = 0; fz = 0; fn = 0; fev = 0; pav = '0;
			mode = '0; errors = 0;
		endfunction

		function logic [63:0] sx(logic [63:0] v, int bits);
			logic [63:0] m;
			m = 64'd1 << (bits - 1);
			return ((v & ((m << 1) - 64'd1)) ^ m) - m;
		endfunction

		function logic [63:0] rnd(logic [63:0] v, logic [63:0] r, logic [63:0] h);
			if (r > h) return v + 64'd1;
			if (r == h) return v + {63'd0, v[0]};
			return v;
		endfunction

		function logic [63:0] accrd(int i);
			return (i < N_ACC) ? acc[i] : 64'd0;
		endfunction

		function logic [63:0] sat48(int x, logic [63:0] clamp);
			logic [63:0] r;
			r = sx(acc[x], 48);
			if (r != acc[x]) fv = 1;
			if (fv) begin
				pav[x] = 1;
				if (mode.saturate) r = r[63] ? ~clamp : clamp;
			end
			return r;
		endfunction

		function logic [31:0] frac_read(logic [63:0] val);
			logic [63:0] v;
			if (mode.short_m) begin
				v = rnd((val >> 24) & 64'hffff, val & 64'hffffff, 64'h800000);
				if (mode.saturate && v > 64'hffff) return 32'h7fff;
				return {16'd0, v[15:0]};
			end
			v = $signed(val) >>> 8;
			if (mode.rnd) v = rnd(v, val & 64'hff, 64'h80);
			if (mode.saturate && sx(v, 32) != v) return v[63] ? 32'h80000000 : 32'h7fffffff;
			return v[31:0];
		endfunction

		function void note_request(mac_in_t q);
			logic [63:0] a, b, p, v, lo, hi;
			logic [31:0] rd;
			int x, s, bi;
			mac_out_t o;
			a = {32'd0, q.operand_a}; b = {32'd0, q.operand_b};
			x = q.acc_index; s = q.src_index; bi = x + 1; rd = '0;
			if (q.opcode <= OP_PSHR) begin
				case (q.opcode)
				OP_MUL_S: begin
					p = sx(a, 32) * sx(b, 32);
					v = sx(p, 40);
					if (v != p) begin
						fv = 1;
						if (mode.saturate) v = p[63] ? ~BIT50 : BIT50;
					end
					prod = v;
				end
				OP_MUL_U: begin
					p = a * b;
					if (p & ~MSK40) begin
						fv = 1;
						p = mode.saturate ? BIT50 : (p & MSK40);
					end
					prod = p;
				end
				OP_MUL_F: begin
					p = sx(a, 32) * sx(b, 32);
					v = $signed(p) >>> 24;
					prod = mode.rnd ? rnd(v, p & 64'hffffff, 64'h800000) : v;
				end
				OP_PSHL: prod = prod << 1;
				default: prod = prod >> 1;
				endcase
			end else if (q.opcode == OP_CLR_FLAGS) begin
				fv = 0; fz = 0; fn = 0; fev = 0;
			end else if (q.opcode <= OP_WR_EXT_U && x < N_ACC
					&& !(q.opcode == OP_MOVE && s >= N_ACC)) begin
				v = acc[x];
				case (q.opcode)
				OP_ACC_ADD: acc[x] = v + prod;
				OP_ACC_SUB: acc[x] = v - prod;
				OP_SAT_S: acc[x] = sat48(x, CLAMP_S);
				OP_SAT_U: begin
					if (v & ~MASK48) fv = 1;
					if (fv) begin
						pav[x] = 1;
						if (mode.saturate) v = (v > BIT53) ? 64'd0 : MASK48;
						else v = v & MASK48;
					end
					acc[x] = v;
				end
				OP_SAT_F: acc[x] = sat48(x, CLAMP_F);
				OP_SET_FLAGS: begin
					if (v == 0) fz = 1;
					else if (v[47]) fn = 1;
					if (pav[x]) fv = 1;
					if (mode.fraction) begin
						p = $signed(v) >>> 40;
						if (p != 0 && p != '1) fev = 1;
					end else if (mode.short_m) begin
						p = $signed(v) >>> 32;
						if (p != 0 && p != '1) fev = 1;
					end else if (v[63:32] != 0) fev = 1;
				end
				OP_RD_F: rd = frac_read(v);
				OP_RD_I: rd = v[31:0];
				OP_RD_SS: rd = (sx(v, 32) == v) ? v[31:0]
					: (v[63] ? 32'h80000000 : 32'h7fffffff);
				OP_RD_US: rd = (v[63:32] != 0) ? 32'hffffffff : v[31:0];
				OP_CLR_ACC: begin acc[x] = 0; pav[x] = 0; end
				OP_MOVE: begin acc[x] = acc[s]; pav[x] = pav[s]; end
				OP_RD_EXT_F: begin
					hi = accrd(bi);
					rd = {hi[47:40], hi[7:0], v[47:40], v[7:0]};
				end
				OP_RD_EXT_I: begin
					hi = accrd(bi);
					rd = {hi[47:32], v[47:32]};
				end
				OP_WR_F, OP_WR_S, OP_WR_U: begin
					acc[x] = (q.opcode == OP_WR_F) ? (sx(a, 32) << 8)
						: (q.opcode == OP_WR_S) ? sx(a, 32) : a;
					pav[x] = 0;
				end
				OP_WR_EXT_F: begin
					lo = (v & EXT_MID) | (sx(a >> 8, 8) << 40) | (a & 64'hff);
					hi = (accrd(bi) & EXT_MID) | (sx(a >> 24, 8) << 40) | ((a >> 16) & 64'hff);
					acc[x] = lo;
					if (bi < N_ACC) acc[bi] = hi;
				end
				OP_WR_EXT_S: begin
					lo = (v & 64'hffffffff) | (sx(a, 16) << 32);
					hi = (accrd(bi) & 64'hffffffff) | (sx(a >> 16, 16) << 32);
					acc[x] = lo;
					if (bi < N_ACC) acc[bi] = hi;
				end
				default: begin
					lo = (v & 64'hffffffff) | ((a & 64'hffff) << 32);
					hi = (accrd(bi) & 64'hffffffff) | ((a & 64'hffff0000) << 16);
					acc[x] = lo;
					if (bi < N_ACC) acc[bi] = hi;
				end
				endcase
			end
			o.read_data = rd; o.overflow = fv; o.zero_flag = fz;
			o.negative_flag = fn; o.ext_overflow = fev; o.pav_flags = pav;
			pending.push_back(o);
		endfunction

		function void check_response(mac_out_t got);
			mac_out_t e;
			if (pending.size() == 0) begin
				$error("response with nothing outstanding: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.read_data !== e.read_data) begin
				$error("read_data exp %h got %h", e.read_data, got.read_data); errors++;
			end
			if (got.overflow !== e.overflow) begin
				$error("overflow exp %b got %b", e.overflow, got.overflow); errors++;
			end
			if (got.zero_flag !== e.zero_flag) begin
				$error("zero_flag exp %b got %b", e.zero_flag, got.zero_flag); errors++;
			end
			if (got.negative_flag !== e.negative_flag) begin
				$error("negative_flag exp %b got %b", e.negative_flag, got.negative_flag);
				errors++;
			end
			if (got.ext_overflow !== e.ext_overflow) begin
				$error("ext_overflow exp %b got %b", e.ext_overflow, got.ext_overflow);
				errors++;
			end
			if (got.pav_flags !== e.pav_flags) begin
				$error("pav_flags exp %h got %h", e.pav_flags, got.pav_flags); errors++;
			end
		endfunction
	endclass

	logic     clk, arst_n;
	logic     in_valid, in_ready, out_valid, out_ready;
	mac_in_t  in_data;
	mac_out_t out_data;
	logic     cfg_we;
	logic [1:0] cfg_index;
	logic     cfg_data;

	int send_idle, sink_stall;
	bit sink_hold;
	mac_scoreboard mac_sb;

	multiply_accumulate_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("multiply_accumulate_unit: mismatch");
		$finish;
	end

	// response side: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) mac_sb.check_response(out_data);
			out_ready <= !sink_hold && ($urandom_range(99) >= sink_stall);
		end
	end

	initial begin
		sink_hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			wait (sink_hold);
			repeat (60) @(posedge clk);
			sink_hold = 0;
		end
	end

	// valid stays high between back-to-back requests; idle gaps drop it
	task automatic send_request(mac_in_t q);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		mac_sb.note_request(q);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (mac_sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_mode(mac_cfg_t m);
		drain();
		cfg_we <= 1; cfg_index <= CFG_SATURATE; cfg_data <= m.saturate; @(posedge clk);
		cfg_index <= CFG_SHORT; cfg_data <= m.short_m; @(posedge clk);
		cfg_index <= CFG_FRACTION; cfg_data <= m.fraction; @(posedge clk);
		cfg_index <= CFG_ROUND; cfg_data <= m.rnd; @(posedge clk);
		cfg_we <= 0;
		mac_sb.mode = m;
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(7))
		0: return 32'h0;
		1: return 32'hffffffff;
		2: return 32'h7fffffff;
		3: return 32'h80000000;
		4: return {24'd0, 8'h80};
		5: return 32'h00800000;
		default: return $urandom;
		endcase
	endfunction

	function automatic mac_in_t rand_request();
		mac_in_t q;
		int k;
		k = $urandom_range(99);
		q.operand_a = edge_word();
		q.operand_b = edge_word();
		q.acc_index = 2'($urandom_range(3));
		q.src_index = 2'($urandom_range(3));
		if (k < 30) q.opcode = opcode_t'($urandom_range(2));
		else if (k < 50) q.opcode = opcode_t'($urandom_range(OP_ACC_SUB, OP_ACC_ADD));
		else if (k < 97) q.opcode = opcode_t'($urandom_range(OP_WR_EXT_U));
		else q.opcode = 5'($urandom_range(31));
		return q;
	endfunction

	initial begin
		mac_in_t q;
		mac_cfg_t m;
		mac_sb = new();
		mac_sb.clear();
		arst_n = 0;
		in_valid = 0; in_data = '0; out_ready = 0;
		cfg_we = 0; cfg_index = CFG_SATURATE; cfg_data = 0;
		send_idle = 0; sink_stall = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: each opcode once with extreme operands, then one unused code
		for (int op = 0; op <= 25; op++) begin
			q.opcode = 5'(op);
			q.operand_a = (op % 2) ? 32'hffffffff : 32'h80000000;
			q.operand_b = (op % 3) ? 32'h7fffffff : 32'hffffffff;
			q.acc_index = (op >= 18) ? 2'd3 : op[1:0];
			q.src_index = op[2:1];
			send_request(q);
		end
		q.opcode = 5'd31; send_request(q);

		for (int ph = 0; ph < 16; ph++) begin
			m = (ph == 15) ? 4'hf : ph[3:0];
			set_mode(m);
			case (ph % 4)
			0: begin send_idle = 0; sink_stall = 0; end
			1: begin send_idle = 77; sink_stall = 0; end
			2: begin send_idle = 0; sink_stall = 77; end
			default: begin send_idle = 14; sink_stall = 14; end
			endcase
			if (ph == 5) sink_hold = 1;
			for (int i = 0; i < 113; i++) send_request(rand_request());
			if (ph == 8) drain();
		end

		drain();
		if (mac_sb.errors == 0 && mac_sb.pending.size() == 0) begin
			$display("multiply_accumulate_unit: match");
		end else begin
			$display("multiply_accumulate_unit: mismatch");
		end
		$finish;
	end
endmodule
